/* rtl/core/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the min-heap priority queue: key width,
// default capacity, command and status codes, and the control word that
// the top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int KEY_W          = 32;
   localparam int OCC_W          = 7;
   localparam int STATUS_W       = 2;
   localparam int HEAP_DEPTH_DEF = 64;

   typedef enum logic {
      CMD_INSERT  = 1'b0,
      CMD_EXTRACT = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Operation broadcast to the whole cell row at once.
   typedef struct packed {
      logic                    ins;
      logic                    ext;
      logic signed [KEY_W-1:0] key;
   } cell_ctl_type;

endpackage

/* rtl/core/bmhq_chan_if.sv */
// ----------------------------------------------------------------------------
// bmhq_req_if / bmhq_rsp_if
// Valid/ready channels for requests into the queue and responses out of it.
// ----------------------------------------------------------------------------
interface bmhq_req_if;
   logic                              valid;
   logic                              ready;
   logic                              cmd;
   logic signed [bmhq_pkg::KEY_W-1:0] key_in;

   modport source (output valid, cmd, key_in, input ready);
   modport sink   (input valid, cmd, key_in, output ready);
endinterface

interface bmhq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bmhq_pkg::KEY_W-1:0]    key_out;
   logic        [bmhq_pkg::STATUS_W-1:0] status;
   logic        [bmhq_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, key_out, status, occupancy, input ready);
   modport sink   (input valid, key_out, status, occupancy, output ready);
endinterface

/* rtl/core/bmhq_cell.sv */
// ----------------------------------------------------------------------------
// bmhq_cell
// One slot of the sorted key row. On insert the slot keeps its key, takes
// the new key, or takes its lower neighbor's key; on extract it takes its
// upper neighbor's key.
// ----------------------------------------------------------------------------
module bmhq_cell #(
   parameter int CNT_W = 7,
   parameter int IDX   = 0
) (
   input  logic                              clock,
   input  bmhq_pkg::cell_ctl_type            ctl,
   input  logic [CNT_W-1:0]                  count,
   input  logic                              prev_lt,
   input  logic signed [bmhq_pkg::KEY_W-1:0] prev_val,
   input  logic signed [bmhq_pkg::KEY_W-1:0] next_val,
   output logic                              lt,
   output logic signed [bmhq_pkg::KEY_W-1:0] val
);

   logic signed [bmhq_pkg::KEY_W-1:0] val_ff;
   logic signed [bmhq_pkg::KEY_W-1:0] val_in;
   logic                              occupied;

   // An empty slot acts as plus infinity, so the row stays sorted.
   assign occupied = count > CNT_W'(IDX);
   assign lt       = !occupied || (ctl.key < val_ff);
   assign val      = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctl.ins) begin
         if (prev_lt) begin
            val_in = prev_val;
         end else if (lt) begin
            val_in = ctl.key;
         end
      end else if (ctl.ext) begin
         val_in = next_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

/* rtl/core/binary_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Priority queue of signed 32-bit keys with insert and extract-minimum.
// ----------------------------------------------------------------------------
// The queue holds up to HEAP_DEPTH keys in a row of cells kept in ascending
// order. An insert compares the new key with all cells at once and shifts
// the larger ones up by one slot, and an extract shifts the whole row down
// by one slot. The response is captured in an output register in the cycle
// after the request is accepted, and a new request is taken in every cycle
// in which that register is empty or being read. Extract from an empty
// queue and insert into a full one return an error status and leave the
// contents unchanged.
module binary_min_heap_queue #(
   parameter int HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bmhq_req_if.sink    req_chan,
   bmhq_rsp_if.source  rsp_chan
);

   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);

   logic [CNT_W-1:0]                  count_ff;
   logic [CNT_W-1:0]                  count_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [bmhq_pkg::KEY_W-1:0] rsp_key_ff;
   logic signed [bmhq_pkg::KEY_W-1:0] rsp_key_in;
   bmhq_pkg::status_type              rsp_status_ff;
   bmhq_pkg::status_type              rsp_status_in;

   logic                              accept;
   logic                              full;
   logic                              empty;
   bmhq_pkg::cell_ctl_type            ctl;

   // Slot i sits at index i+1; both ends are dummy neighbors.
   logic signed [bmhq_pkg::KEY_W-1:0] vals [0:HEAP_DEPTH+1];
   logic                              lts  [0:HEAP_DEPTH];

   assign accept = req_chan.valid && req_chan.ready;
   assign full   = count_ff == CNT_W'(HEAP_DEPTH);
   assign empty  = count_ff == '0;

   assign ctl.ins = accept && (req_chan.cmd == bmhq_pkg::CMD_INSERT) && !full;
   assign ctl.ext = accept && (req_chan.cmd == bmhq_pkg::CMD_EXTRACT) && !empty;
   assign ctl.key = req_chan.key_in;

   assign vals[0]            = '0;
   assign vals[HEAP_DEPTH+1] = '0;
   assign lts[0]             = 1'b0;

   for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
      bmhq_cell #(
         .CNT_W (CNT_W),
         .IDX   (i)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .count    (count_ff),
         .prev_lt  (lts[i]),
         .prev_val (vals[i]),
         .next_val (vals[i+2]),
         .lt       (lts[i+1]),
         .val      (vals[i+1])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_key_in    = '0;
         rsp_status_in = bmhq_pkg::STATUS_OK;
         if (req_chan.cmd == bmhq_pkg::CMD_INSERT) begin
            if (full) begin
               rsp_status_in = bmhq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (empty) begin
               rsp_status_in = bmhq_pkg::STATUS_EMPTY;
            end else begin
               count_in   = count_ff - CNT_W'(1);
               rsp_key_in = vals[1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
   end

   // No request is taken while reset is held.
   assign req_chan.ready     = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.key_out   = rsp_key_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.occupancy = bmhq_pkg::OCC_W'(count_ff);

`ifndef SYNTH
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HEAP_DEPTH))
      else $error("key count exceeds capacity");

   a_extract_ok : assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.cmd == bmhq_pkg::CMD_EXTRACT && !empty) |=>
      (rsp_valid_ff && rsp_status_ff == bmhq_pkg::STATUS_OK
       && count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("extract from nonempty queue did not succeed");

   a_full_hold : assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.cmd == bmhq_pkg::CMD_INSERT && full) |=>
      (rsp_status_ff == bmhq_pkg::STATUS_FULL && $stable(count_ff)))
      else $error("insert into full queue changed state");

   a_row_sorted : assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (vals[1] <= vals[2]))
      else $error("smallest key is not at the head of the row");
`endif

endmodule

/* tb/tb_binary_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// tb_binary_min_heap_queue
// Self-checking bench for the min-heap priority queue. A queue of insert and
// extract requests is filled phase by phase; a clocked driver feeds it to the block
// and a clocked monitor predicts every response with its own array-backed
// heap and compares key, status and occupancy field by field. Traffic runs
// through phases with and without sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_binary_min_heap_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY     = bmhq_pkg::HEAP_DEPTH_DEF;
   localparam int KEY_W        = bmhq_pkg::KEY_W;
   localparam int OCC_W        = bmhq_pkg::OCC_W;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 8;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   typedef struct {
      bmhq_pkg::cmd_type       op;
      logic signed [KEY_W-1:0] key;
   } heap_op_type;

   typedef struct {
      logic signed [KEY_W-1:0] key;
      bmhq_pkg::status_type    status;
      logic [OCC_W-1:0]        occ;
   } heap_rsp_type;

   logic clock;
   logic reset;

   bmhq_req_if req_chan();
   bmhq_rsp_if rsp_chan();

   binary_min_heap_queue #(
      .HEAP_DEPTH(CAPACITY)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   heap_op_type             pending_ops[$];
   heap_rsp_type            predicted_rsps[$];
   logic signed [KEY_W-1:0] heap_keys[CAPACITY];
   int                      heap_size;
   int                      plan_count;
   int                      send_idle_pct;
   int                      stall_pct;
   int                      error_count;
   int                      rsp_index;
   int                      cycle_count;
   logic                    req_taken;

   always #5 clock = ~clock;

   // Array-backed min-heap, updated in acceptance order.
   function automatic heap_rsp_type heap_apply(bmhq_pkg::cmd_type op,
                                               logic signed [KEY_W-1:0] key);
      heap_rsp_type            r;
      int                      pos;
      int                      up;
      int                      best;
      logic signed [KEY_W-1:0] tmp;
      r.key    = '0;
      r.status = bmhq_pkg::STATUS_OK;
      if (op == bmhq_pkg::CMD_INSERT) begin
         if (heap_size >= CAPACITY) begin
            r.status = bmhq_pkg::STATUS_FULL;
         end else begin
            pos = heap_size;
            heap_keys[pos] = key;
            heap_size++;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (!(heap_keys[pos] < heap_keys[up])) break;
               tmp = heap_keys[pos];
               heap_keys[pos] = heap_keys[up];
               heap_keys[up] = tmp;
               pos = up;
            end
         end
      end else if (heap_size == 0) begin
         r.status = bmhq_pkg::STATUS_EMPTY;
      end else begin
         r.key = heap_keys[0];
         heap_size--;
         heap_keys[0] = heap_keys[heap_size];
         pos = 0;
         while (pos < heap_size) begin
            best = pos;
            // Move only to a strictly smaller child; the left one wins a tie.
            if (2 * pos + 1 < heap_size && heap_keys[2 * pos + 1] < heap_keys[best])
               best = 2 * pos + 1;
            if (2 * pos + 2 < heap_size && heap_keys[2 * pos + 2] < heap_keys[best])
               best = 2 * pos + 2;
            if (best == pos) break;
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[best];
            heap_keys[best] = tmp;
            pos = best;
         end
      end
      r.occ = heap_size[OCC_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t ns: response %0d %s: got %0h, expected %0h",
               $time, rsp_index, what, got, want);
      error_count++;
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(3))
         0: return $signed(int'($urandom_range(16)) - 8);
         1: begin
            case ($urandom_range(5))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return KEY_MIN + 1;
               3: return KEY_MAX - 1;
               4: return -1;
               default: return 0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic push_op(bmhq_pkg::cmd_type op, logic signed [KEY_W-1:0] key);
      heap_op_type item;
      item.op  = op;
      item.key = key;
      pending_ops.push_back(item);
      if (op == bmhq_pkg::CMD_INSERT && plan_count < CAPACITY) plan_count++;
      if (op == bmhq_pkg::CMD_EXTRACT && plan_count > 0) plan_count--;
   endtask

   // Bursts that fill the heap to the brim and past it, drain it dry and past empty, or mix both.
   task automatic build_traffic(int n_ops, bit begin_with_fill);
      int issued;
      int pick;
      int burst_len;
      int insert_pct;
      issued = 0;
      while (issued < n_ops) begin
         pick = (begin_with_fill && issued == 0) ? 0 : $urandom_range(99);
         if (pick < 20) begin
            while (plan_count < CAPACITY) begin
               push_op(bmhq_pkg::CMD_INSERT, pick_key());
               issued++;
            end
            repeat ($urandom_range(1, 3)) begin
               push_op(bmhq_pkg::CMD_INSERT, pick_key());
               issued++;
            end
         end else if (pick < 40) begin
            while (plan_count > 0) begin
               push_op(bmhq_pkg::CMD_EXTRACT, pick_key());
               issued++;
            end
            repeat ($urandom_range(1, 3)) begin
               push_op(bmhq_pkg::CMD_EXTRACT, pick_key());
               issued++;
            end
         end else begin
            burst_len  = $urandom_range(10, 60);
            insert_pct = $urandom_range(25, 75);
            repeat (burst_len) begin
               if ($urandom_range(99) < insert_pct)
                  push_op(bmhq_pkg::CMD_INSERT, pick_key());
               else
                  push_op(bmhq_pkg::CMD_EXTRACT, pick_key());
               issued++;
            end
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_chan.valid || predicted_rsps.size() != 0);
   endtask

   // Request driver: changes inputs on the falling edge only.
   always @(negedge clock) begin
      heap_op_type item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = pending_ops.pop_front();
            req_chan.valid  <= 1'b1;
            req_chan.cmd    <= item.op;
            req_chan.key_in <= item.key;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Monitor: predicts on each accepted request, checks each accepted response.
   always @(posedge clock) begin
      heap_rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready)
            predicted_rsps.push_back(heap_apply(bmhq_pkg::cmd_type'(req_chan.cmd),
                                                req_chan.key_in));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (predicted_rsps.size() == 0) begin
               report_mismatch("arrived with none outstanding", rsp_chan.key_out, 0);
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_chan.key_out !== want.key)
                  report_mismatch("key_out", rsp_chan.key_out, want.key);
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", rsp_chan.status, want.status);
               if (rsp_chan.occupancy !== want.occ)
                  report_mismatch("occupancy", rsp_chan.occupancy, want.occ);
            end
            rsp_index++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.cmd    = bmhq_pkg::CMD_INSERT;
      req_chan.key_in = '0;
      rsp_chan.ready  = 1'b0;
      req_taken       = 1'b0;
      heap_size       = 0;
      plan_count      = 0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      error_count     = 0;
      rsp_index       = 0;
      cycle_count     = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening: empty extract, key extremes, ties, drain past empty.
      push_op(bmhq_pkg::CMD_EXTRACT, KEY_MAX);
      push_op(bmhq_pkg::CMD_INSERT, 0);
      push_op(bmhq_pkg::CMD_INSERT, KEY_MAX);
      push_op(bmhq_pkg::CMD_INSERT, KEY_MIN);
      push_op(bmhq_pkg::CMD_INSERT, -1);
      push_op(bmhq_pkg::CMD_INSERT, 1);
      repeat (3) push_op(bmhq_pkg::CMD_INSERT, 5);
      repeat (9) push_op(bmhq_pkg::CMD_EXTRACT, KEY_MIN);
      push_op(bmhq_pkg::CMD_INSERT, KEY_MAX);
      push_op(bmhq_pkg::CMD_INSERT, KEY_MAX);
      push_op(bmhq_pkg::CMD_EXTRACT, 0);
      push_op(bmhq_pkg::CMD_EXTRACT, -1);

      // Each phase starts only once the previous one has fully drained, so
      // the sender is held off until every response is back.
      build_traffic(170, 1'b1);
      wait_drained();

      send_idle_pct = 88;
      build_traffic(170, 1'b0);
      wait_drained();

      send_idle_pct = 0;
      stall_pct     = 88;
      build_traffic(170, 1'b0);
      wait_drained();

      send_idle_pct = 36;
      stall_pct     = 36;
      build_traffic(170, 1'b0);
      wait_drained();

      send_idle_pct = 0;
      stall_pct     = 0;
      build_traffic(170, 1'b0);
      wait_drained();

      repeat (SETTLE_TICKS) @(posedge clock);
      if (predicted_rsps.size() != 0)
         report_mismatch("responses never arrived", 0, predicted_rsps.size());

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
